// ===== rtl/obrb_pkg.sv =====
// Shared types and constants for the overwriting byte ring buffer.
package obrb_pkg;

    localparam int DEPTH     = 64;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CAP_W     = $clog2(DEPTH + 1);
    localparam int CFG_W     = 7;
    localparam int CNT_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 2;
    localparam int S_DATA_W  = 8;
    localparam int S_USER_W  = 8;
    localparam int M_DATA_W  = 24;
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(64);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

// ===== rtl/obrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module obrb_ram #(
    parameter int DATA_W     = 8,
    parameter int ADDR_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(ADDR_DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]             wdata,
    input  logic [$clog2(ADDR_DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]             rdata
);

    logic [DATA_W-1:0] mem [ADDR_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/obrb_ctrl.sv =====
// Controller: request sequencing and result valid tracking.
module obrb_ctrl
    import obrb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ctrl_cmd_t ctrl
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ctrl.capture = 1'b0;
        ctrl.execute = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // wait for the result register to free up
                if (!out_valid_reg || m_tready) begin
                    ctrl.execute = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (ctrl.execute) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/obrb_dp.sv =====
// Datapath: pointers, full flag, capacity register, byte store and result register.
module obrb_dp
    import obrb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           ctrl,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [S_USER_W-1:0] s_tuser,
    input  logic                cfg_valid,
    input  logic [CFG_W-1:0]    cfg_data,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int CMP_W = (CFG_W > CAP_W) ? CFG_W : CAP_W;
    localparam int D_W   = CAP_W + 2;

    cmd_t              cmd_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic              full_reg, full_next;
    logic [CFG_W-1:0]  cap_cfg_reg;
    logic [M_DATA_W-1:0] out_reg, out_next;

    logic [BYTE_W-1:0] ram_rdata;
    logic              ram_we;
    logic [CMP_W-1:0]  cfg_ext;
    logic [CAP_W-1:0]  cap;
    logic              empty_now;
    logic              empty_next;
    logic [BYTE_W-1:0] rd_byte;
    logic              ok;
    logic signed [D_W-1:0] diff;
    logic [CAP_W-1:0]  fill;

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] c);
        logic [CAP_W:0] inc;
        logic [PTR_W-1:0] res;
        inc = (CAP_W+1)'(p) + 1'b1;
        if (inc >= {1'b0, c}) begin
            res = '0;
        end else begin
            res = inc[PTR_W-1:0];
        end
        return res;
    endfunction

    obrb_ram #(
        .DATA_W     (BYTE_W),
        .ADDR_DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (data_reg),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    assign ram_we = ctrl.execute && (cmd_reg == CMD_PUT);

    // capacity clamped to 1..DEPTH
    always_comb begin
        cfg_ext = CMP_W'(cap_cfg_reg);
        if (cfg_ext == '0) begin
            cap = CAP_W'(1);
        end else if (cfg_ext > CMP_W'(DEPTH)) begin
            cap = CAP_W'(DEPTH);
        end else begin
            cap = cfg_ext[CAP_W-1:0];
        end
    end

    assign empty_now = !full_reg && (wp_reg == rp_reg);

    always_comb begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        full_next = full_reg;
        rd_byte   = '0;
        ok        = 1'b0;
        case (cmd_reg)
            CMD_PUT: begin
                wp_next = ptr_adv(wp_reg, cap);
                if (full_reg) begin
                    rp_next = ptr_adv(rp_reg, cap);
                end
                if (wp_next == rp_next) begin
                    full_next = 1'b1;
                end else begin
                    ok = 1'b1;
                end
            end
            CMD_GET: begin
                if (!empty_now) begin
                    rd_byte   = ram_rdata;
                    rp_next   = ptr_adv(rp_reg, cap);
                    full_next = 1'b0;
                    ok        = 1'b1;
                end
            end
            CMD_CLEAR: begin
                wp_next   = '0;
                rp_next   = '0;
                full_next = 1'b0;
                ok        = 1'b1;
            end
            default: ;
        endcase

        diff = $signed(D_W'(wp_next)) - $signed(D_W'(rp_next));
        if (diff < 0) begin
            diff = diff + $signed(D_W'(cap));
        end
        if (diff < 0) begin
            diff = '0;
        end
        if (diff > $signed(D_W'(cap))) begin
            diff = $signed(D_W'(cap));
        end
        fill       = full_next ? cap : diff[CAP_W-1:0];
        empty_next = !full_next && (wp_next == rp_next);

        out_next = '0;
        out_next[BYTE_W-1:0]                 = rd_byte;
        out_next[BYTE_W]                     = ok;
        out_next[BYTE_W+1 +: CNT_W]          = CNT_W'(fill);
        out_next[BYTE_W+1+CNT_W]             = empty_next;
        out_next[BYTE_W+2+CNT_W]             = full_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            full_reg    <= 1'b0;
            cap_cfg_reg <= CAP_RESET;
        end else begin
            if (ctrl.execute) begin
                wp_reg   <= wp_next;
                rp_reg   <= rp_next;
                full_reg <= full_next;
            end
            if (cfg_valid) begin
                cap_cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg  <= cmd_t'(s_tuser[CMD_W-1:0]);
            data_reg <= s_tdata[BYTE_W-1:0];
        end
        if (ctrl.execute) begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

endmodule

// ===== rtl/overwriting_byte_ring_buffer.sv =====
// Top level of the overwriting byte ring buffer.
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    tuser: cmd; tdata: write_data
//  m_        out        m_tvalid / m_tready    tdata: read_data, ok, count, empty, full
//  cfg_      in         cfg_valid / cfg_ready  capacity_in_use
//
// Each request is captured, together with the byte store read, and then executed.
// The byte store has one registered read port, so the read byte is only ready for execute.
// A request may be accepted while the previous result waits on m_tready; execute
// then holds until the result register frees up.
// Reset clears pointers and full flag and sets capacity to 64; the store is not cleared.
module overwriting_byte_ring_buffer
    import obrb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // [7:0] write_data
    input  logic [S_USER_W-1:0] s_tuser,  // [1:0] cmd, [7:2] zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // [7:0] read_data, [8] ok, [15:9] count,
                                          // [16] empty_res, [17] full_res, [23:18] zero
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data  // [6:0] capacity_in_use
);

    ctrl_cmd_t ctrl;

    assign cfg_ready = 1'b1;

    obrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    obrb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the overwriting byte ring buffer, with a shadow ring predicting each reply.
module tb;
    import obrb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [5:0]        pad;
        logic              full_res;
        logic              empty_res;
        logic [CNT_W-1:0]  count;
        logic              ok;
        logic [BYTE_W-1:0] read_data;
    } reply_t;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_EVERY_FOURTH,
        READY_RARELY
    } stall_mode_t;

    class byte_ring_shadow;
        logic [BYTE_W-1:0] slots[DEPTH];
        bit                slot_written[DEPTH];
        int                wr_ptr;
        int                rd_ptr;
        bit                full;
        logic [CFG_W-1:0]  capacity_reg;
        reply_t            pending_replies[$];
        int                errors;
        int                replies_checked;
        int                overwrites;
        int                fulls_seen;
        int                cmd_seen[4];

        function new();
            wr_ptr = 0;
            rd_ptr = 0;
            full = 1'b0;
            capacity_reg = CAP_RESET;
            errors = 0;
            replies_checked = 0;
            overwrites = 0;
            fulls_seen = 0;
            foreach (slot_written[i]) slot_written[i] = 1'b0;
            foreach (cmd_seen[i]) cmd_seen[i] = 0;
        endfunction

        function int used_slots();
            int c;
            c = capacity_reg;
            if (c < 1) c = 1;
            if (c > DEPTH) c = DEPTH;
            return c;
        endfunction

        function int step_ptr(int p, int cap);
            return (p + 1 >= cap) ? 0 : p + 1;
        endfunction

        function bit is_empty();
            return !full && wr_ptr == rd_ptr;
        endfunction

        function int fill_level(int cap);
            int d;
            if (full) return cap;
            d = wr_ptr - rd_ptr;
            if (d < 0) d += cap;
            if (d < 0) d = 0;
            if (d > cap) d = cap;
            return d;
        endfunction

        // a get must never land on a slot not yet written since reset
        function bit get_is_safe();
            return is_empty() || slot_written[rd_ptr % DEPTH];
        endfunction

        function void set_capacity(logic [CFG_W-1:0] value);
            capacity_reg = value;
        endfunction

        function void log_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data);
            reply_t r;
            int cap;
            cap = used_slots();
            r = '0;
            cmd_seen[cmd]++;
            case (cmd)
                CMD_PUT: begin
                    slots[wr_ptr % DEPTH] = data;
                    slot_written[wr_ptr % DEPTH] = 1'b1;
                    wr_ptr = step_ptr(wr_ptr, cap);
                    if (full) begin
                        rd_ptr = step_ptr(rd_ptr, cap);
                        overwrites++;
                    end
                    if (wr_ptr == rd_ptr) full = 1'b1;
                    else r.ok = 1'b1;
                end
                CMD_GET: begin
                    if (!is_empty()) begin
                        r.read_data = slots[rd_ptr % DEPTH];
                        rd_ptr = step_ptr(rd_ptr, cap);
                        full = 1'b0;
                        r.ok = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    wr_ptr = 0;
                    rd_ptr = 0;
                    full = 1'b0;
                    r.ok = 1'b1;
                end
                default: begin
                end
            endcase
            r.count = CNT_W'(fill_level(cap));
            r.empty_res = is_empty();
            r.full_res = full;
            if (full) fulls_seen++;
            pending_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(logic [M_DATA_W-1:0] bits);
            reply_t got;
            reply_t want;
            got = bits;
            replies_checked++;
            if (pending_replies.size() == 0) begin
                $error("reply with no request outstanding: %h", bits);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("ok", want.ok, got.ok);
            compare_field("count", want.count, got.count);
            compare_field("empty_res", want.empty_res, got.empty_res);
            compare_field("full_res", want.full_res, got.full_res);
            compare_field("pad", want.pad, got.pad);
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;  // [7:0] write_data
    logic [S_USER_W-1:0] s_tuser = '0;  // [1:0] cmd, [7:2] zero
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;       // [7:0] read_data, [8] ok, [15:9] count,
                                        // [16] empty_res, [17] full_res, [23:18] zero
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data = '0;

    byte_ring_shadow ring = new();
    int              idle_cycles = 0;
    int              stall_left = 0;
    stall_mode_t     stall_mode = READY_ALWAYS;
    int              burst_left = 0;
    int              cfg_writes = 0;

    overwriting_byte_ring_buffer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            READY_ALWAYS:       m_tready = 1'b1;
            READY_MOSTLY:       m_tready = ($urandom_range(0, 3) != 0);
            READY_EVERY_FOURTH: m_tready = (stall_left % 4 == 0);
            default:            m_tready = ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ring.check_reply(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = S_USER_W'(cmd);
        s_tdata = data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ring.log_request(cmd, data);
    endtask

    // clear_pct and get_pct shape the mix; unused commands ride along at 3%
    task automatic random_request(input int get_pct, input int clear_pct);
        logic [CMD_W-1:0] cmd;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < get_pct) cmd = CMD_GET;
        else if (roll < get_pct + clear_pct) cmd = CMD_CLEAR;
        else if (roll < get_pct + clear_pct + 3) cmd = CMD_UNUSED;
        else cmd = CMD_PUT;
        if (cmd == CMD_GET && !ring.get_is_safe()) cmd = CMD_PUT;
        send_request(cmd, 8'($urandom));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (ring.pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        ring.set_capacity(value);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        int phase_caps[10];
        int fill_len;
        int mix_len;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // default capacity: empty get, unused command, byte extremes, clear
        send_request(CMD_GET, 8'hFF);
        send_request(CMD_UNUSED, 8'hFF);
        send_request(CMD_PUT, 8'h00);
        send_request(CMD_PUT, 8'hFF);
        send_request(CMD_PUT, 8'h5A);
        send_request(CMD_GET, 8'h00);
        send_request(CMD_UNUSED, 8'h00);
        send_request(CMD_GET, 8'hA5);
        send_request(CMD_GET, 8'h00);
        send_request(CMD_GET, 8'h00);
        send_request(CMD_CLEAR, 8'hFF);

        // single slot: every put fills, the second overwrites
        write_capacity(CFG_W'(1));
        send_request(CMD_PUT, 8'h81);
        send_request(CMD_PUT, 8'h7E);
        send_request(CMD_GET, 8'h00);
        send_request(CMD_GET, 8'h00);

        // zero behaves as one slot
        write_capacity(CFG_W'(0));
        send_request(CMD_PUT, 8'h33);
        send_request(CMD_GET, 8'h00);

        write_capacity(CFG_W'(3));
        send_request(CMD_PUT, 8'h01);
        send_request(CMD_PUT, 8'h02);
        send_request(CMD_PUT, 8'h03);
        send_request(CMD_PUT, 8'h04);
        send_request(CMD_CLEAR, 8'h00);
        send_request(CMD_GET, 8'h00);

        phase_caps = '{64, 127, 1, 2, 5, 0, 0, 16, 7, 65};
        phase_caps[5] = $urandom_range(1, 64);
        phase_caps[6] = $urandom_range(0, 127);
        foreach (phase_caps[p]) begin
            write_capacity(CFG_W'(phase_caps[p]));
            // without a clear the old pointers carry over into the new capacity
            if ($urandom_range(0, 1) != 0) send_request(CMD_CLEAR, 8'($urandom));
            fill_len = ring.used_slots() + $urandom_range(1, 8);
            repeat (fill_len) random_request(0, 0);
            mix_len = $urandom_range(5, 10);
            repeat (mix_len) random_request(70, 2);
            repeat (mix_len) random_request(40, 4);
        end

        wait_drained();
        $display("summary: %0d puts, %0d gets, %0d clears, %0d unused commands, %0d replies checked",
                 ring.cmd_seen[CMD_PUT], ring.cmd_seen[CMD_GET], ring.cmd_seen[CMD_CLEAR],
                 ring.cmd_seen[CMD_UNUSED], ring.replies_checked);
        $display("summary: %0d oldest-byte overwrites, %0d full replies, %0d capacity writes",
                 ring.overwrites, ring.fulls_seen, cfg_writes);
        if (ring.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
